@@ rtl/core/hvn_pkg.sv @@
// Shared types and constants of the heightfield vertex normal stream unit.
package hvn_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic [CFG_IW-1:0] {
        REG_GRID_WIDTH    = 3'd0,
        REG_GRID_ROWS     = 3'd1,
        REG_SPACING_X     = 3'd2,
        REG_SPACING_Z     = 3'd3,
        REG_HEIGHT_OFFSET = 3'd4,
        REG_UP_BIAS       = 3'd5,
        REG_CENTER_ORIGIN = 3'd6,
        REG_OUTPUT_MASK   = 3'd7
    } cfg_reg_t;

    localparam logic [30:0] MIN_UP = 31'd66;

    localparam int DIV_NW = 46;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 17;
    localparam int SQ_XW  = 64;
    localparam int SQ_RW  = 32;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_QW-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [SQ_XW-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SQ_RW-1:0] root;
    } sqrt_rsp_t;

endpackage

@@ rtl/core/heightfield_vertex_normal_stream_unit.sv @@
// Top level of the heightfield vertex normal stream unit.
// Height samples enter in raster order and are kept in a two-row line store
// of 2*MAX_WIDTH words; the vertex of sample i leaves when item i+width
// arrives. The first width items of a frame are stored and make no vertex.
// Each later item takes four store reads and one store write, seven
// products from the shared 32x32 multiplier and, as the output mask
// enables them, a 32-step square root and a division in the shared
// divider for each of the three normal components and two texture
// coordinates. One finished vertex waits in the output register while
// the next item is taken. The store needs no clearing after reset.
module heightfield_vertex_normal_stream_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hvn_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [hvn_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic signed [31:0]          height,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          pos_x,
    output logic signed [31:0]          pos_y,
    output logic signed [31:0]          pos_z,
    output logic signed [15:0]          norm_x,
    output logic signed [15:0]          norm_y,
    output logic signed [15:0]          norm_z,
    output logic [15:0]                 tex_u,
    output logic [15:0]                 tex_v
);

    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int GW    = (WW > 11) ? WW : 11;
    localparam int NW    = hvn_pkg::DIV_NW;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_PREP, S_MUL, S_SQRT_GO, S_SQRT_WAIT,
        S_DIV_GO, S_DIV_WAIT, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [WW-1:0]     fill_reg, fill_next;
    logic              primed_reg, primed_next;
    logic [XW-1:0]     col_reg, col_next;
    logic [15:0]       row_reg, row_next;
    logic [10:0]       gw_reg, gw_next;
    logic [15:0]       gr_reg, gr_next;
    logic [30:0]       sx_reg, sx_next;
    logic [30:0]       sz_reg, sz_next;
    logic signed [31:0] off_reg, off_next;
    logic [30:0]       bias_reg, bias_next;
    logic              ctr_reg, ctr_next;
    logic [1:0]        mask_reg, mask_next;
    logic [2:0]        rd_cnt_reg, rd_cnt_next;
    logic [2:0]        mul_cnt_reg, mul_cnt_next;
    logic [2:0]        div_idx_reg, div_idx_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [31:0] sample_reg, sample_next;
    logic [AW-1:0]     vs_reg, vs_next;
    logic signed [31:0] hs_reg, hs_next;
    logic signed [31:0] hl_reg, hl_next;
    logic signed [31:0] hr_reg, hr_next;
    logic signed [31:0] hd_reg, hd_next;
    logic [30:0]       mag_reg [3];
    logic [30:0]       mag_next [3];
    logic [2:0]        neg_reg, neg_next;
    logic [31:0]       px_reg, px_next;
    logic [31:0]       ox_reg, ox_next;
    logic [31:0]       pz_reg, pz_next;
    logic [31:0]       oz_reg, oz_next;
    logic [63:0]       sum_reg, sum_next;
    logic [31:0]       n_reg, n_next;
    logic [31:0]       py_reg, py_next;
    logic [15:0]       nrm_reg [3];
    logic [15:0]       nrm_next [3];
    logic [15:0]       tu_reg, tu_next;
    logic [15:0]       tv_reg, tv_next;
    logic [63:0]       prod_reg;

    logic [31:0]       pos_x_reg, pos_x_next;
    logic [31:0]       pos_y_reg, pos_y_next;
    logic [31:0]       pos_z_reg, pos_z_next;
    logic [15:0]       onx_reg, onx_next;
    logic [15:0]       ony_reg, ony_next;
    logic [15:0]       onz_reg, onz_next;
    logic [15:0]       otu_reg, otu_next;
    logic [15:0]       otv_reg, otv_next;

    logic [WW-1:0]     w_eff;
    logic [15:0]       h_eff;
    logic [GW-1:0]     gw_ext;
    logic              in_accept;
    logic signed [31:0] in_sample;
    logic [AW-1:0]     vs_calc, vsm1, vsp1, vsmw, wp_inc;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic [31:0]       mul_a, mul_b;
    logic [31:0]       w_m1, h_m1;
    logic              job_en;
    logic              load_out;
    logic signed [31:0] bl, br, bd, bu;
    logic signed [32:0] dx, dz, y33;
    logic [32:0]       mx, mz, mu;
    logic [1:0]        sh;

    hvn_pkg::div_req_t  dv_req;
    hvn_pkg::div_rsp_t  dv_rsp;
    hvn_pkg::sqrt_req_t sq_req;
    hvn_pkg::sqrt_rsp_t sq_rsp;

    function automatic logic [AW-1:0] sub_wrap(logic [AW-1:0] a, logic [WW-1:0] b);
        logic [AW:0] t;
        if (a >= AW'(b))
        begin
            t = {1'b0, a} - (AW+1)'(b);
        end
        else
        begin
            t = {1'b0, a} + (AW+1)'(DEPTH) - (AW+1)'(b);
        end
        return t[AW-1:0];
    endfunction

    assign gw_ext = GW'(gw_reg);
    always_comb
    begin
        if (gw_ext < GW'(4))
        begin
            w_eff = WW'(4);
        end
        else if (gw_ext > GW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = gw_ext[WW-1:0];
        end
    end
    assign h_eff = (gr_reg < 16'd4) ? 16'd4 : gr_reg;
    assign w_m1  = 32'(w_eff) - 32'd1;
    assign h_m1  = 32'(h_eff) - 32'd1;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_sample = kind ? 32'sd0 : height;

    assign vs_calc = sub_wrap(wp_reg, w_eff);
    assign vsm1    = (vs_reg == '0) ? AW'(DEPTH - 1) : vs_reg - 1'b1;
    assign vsp1    = (vs_reg == AW'(DEPTH - 1)) ? '0 : vs_reg + 1'b1;
    assign vsmw    = sub_wrap(vs_reg, w_eff);
    assign wp_inc  = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        case (rd_cnt_reg)
            3'd0:    ram_raddr = vs_reg;
            3'd1:    ram_raddr = vsm1;
            3'd2:    ram_raddr = vsp1;
            default: ram_raddr = vsmw;
        endcase
    end

    assign ram_we    = (in_accept && !primed_reg) || (state_reg == S_READ && rd_cnt_reg == 3'd4);
    assign ram_waddr = wp_reg;
    assign ram_wdata = (state_reg == S_READ) ? sample_reg : in_sample;

    hvn_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_lines (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        case (mul_cnt_reg)
            3'd0:    begin mul_a = 32'(col_reg); mul_b = 32'(sx_reg); end
            3'd1:    begin mul_a = 32'(sx_reg);  mul_b = w_m1;        end
            3'd2:    begin mul_a = 32'(row_reg); mul_b = 32'(sz_reg); end
            3'd3:    begin mul_a = 32'(sz_reg);  mul_b = h_m1;        end
            3'd4:    begin mul_a = 32'(mag_reg[0]); mul_b = 32'(mag_reg[0]); end
            3'd5:    begin mul_a = 32'(mag_reg[1]); mul_b = 32'(mag_reg[1]); end
            default: begin mul_a = 32'(mag_reg[2]); mul_b = 32'(mag_reg[2]); end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        bl  = (col_reg != '0) ? hl_reg : hs_reg;
        br  = (WW'(col_reg) + 1'b1 < w_eff) ? hr_reg : hs_reg;
        bd  = (row_reg != '0) ? hd_reg : hs_reg;
        bu  = (17'(row_reg) + 17'd1 < 17'(h_eff)) ? sample_reg : hs_reg;
        dx  = 33'(br) - 33'(bl);
        dz  = 33'(bu) - 33'(bd);
        y33 = 33'(hs_reg) + 33'(off_reg);
        mx  = dx[32] ? 33'(-dx) : 33'(dx);
        mz  = dz[32] ? 33'(-dz) : 33'(dz);
        mu  = 33'((bias_reg < hvn_pkg::MIN_UP) ? hvn_pkg::MIN_UP : bias_reg);
        if (mx[32] || mz[32])
        begin
            sh = 2'd2;
        end
        else if (mx[31] || mz[31] || mu[31])
        begin
            sh = 2'd1;
        end
        else
        begin
            sh = 2'd0;
        end
    end

    assign job_en = (div_idx_reg < 3'd3) ? mask_reg[0] : mask_reg[1];

    always_comb
    begin
        dv_req.start = (state_reg == S_DIV_GO) && (div_idx_reg < 3'd5) && job_en;
        case (div_idx_reg)
            3'd0, 3'd1, 3'd2:
            begin
                dv_req.num = (NW'(mag_reg[div_idx_reg[1:0]]) << 14) + NW'(n_reg >> 1);
                dv_req.den = n_reg;
            end
            3'd3:
            begin
                dv_req.num = (NW'(col_reg) << 16) + NW'(w_m1 >> 1);
                dv_req.den = w_m1;
            end
            default:
            begin
                dv_req.num = (NW'(row_reg) << 16) + NW'(h_m1 >> 1);
                dv_req.den = h_m1;
            end
        endcase
    end

    assign sq_req.start    = (state_reg == S_SQRT_GO);
    assign sq_req.radicand = sum_reg;

    hvn_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dv_req),
        .rsp  (dv_rsp)
    );

    hvn_isqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (sq_req),
        .rsp  (sq_rsp)
    );

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        primed_next    = primed_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        gw_next        = gw_reg;
        gr_next        = gr_reg;
        sx_next        = sx_reg;
        sz_next        = sz_reg;
        off_next       = off_reg;
        bias_next      = bias_reg;
        ctr_next       = ctr_reg;
        mask_next      = mask_reg;
        rd_cnt_next    = rd_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        div_idx_next   = div_idx_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        vs_next        = vs_reg;
        hs_next        = hs_reg;
        hl_next        = hl_reg;
        hr_next        = hr_reg;
        hd_next        = hd_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        px_next        = px_reg;
        ox_next        = ox_reg;
        pz_next        = pz_reg;
        oz_next        = oz_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        py_next        = py_reg;
        nrm_next       = nrm_reg;
        tu_next        = tu_reg;
        tv_next        = tv_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        onx_next       = onx_reg;
        ony_next       = ony_reg;
        onz_next       = onz_reg;
        otu_next       = otu_reg;
        otv_next       = otv_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_sample;
                    if (primed_reg)
                    begin
                        vs_next     = vs_calc;
                        rd_cnt_next = '0;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        wp_next   = wp_inc;
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg + 1'b1 == w_eff)
                        begin
                            primed_next = 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                case (rd_cnt_reg)
                    3'd1:    hs_next = ram_rdata;
                    3'd2:    hl_next = ram_rdata;
                    3'd3:    hr_next = ram_rdata;
                    3'd4:    hd_next = ram_rdata;
                    default: ;
                endcase
                if (rd_cnt_reg == 3'd4)
                begin
                    wp_next    = wp_inc;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                mag_next[0] = 31'(mx >> sh);
                mag_next[1] = 31'(mu >> sh);
                mag_next[2] = 31'(mz >> sh);
                neg_next    = {!dz[32] && (dz != '0), 1'b0, !dx[32] && (dx != '0)};
                if (y33 > 33'sh0_7FFF_FFFF)
                begin
                    py_next = 32'h7FFF_FFFF;
                end
                else if (y33 < -33'sh0_8000_0000)
                begin
                    py_next = 32'h8000_0000;
                end
                else
                begin
                    py_next = 32'(y33);
                end
                nrm_next[0]  = '0;
                nrm_next[1]  = '0;
                nrm_next[2]  = '0;
                tu_next      = '0;
                tv_next      = '0;
                mul_cnt_next = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                mul_cnt_next = mul_cnt_reg + 1'b1;
                case (mul_cnt_reg)
                    3'd1:    px_next  = prod_reg[31:0];
                    3'd2:    ox_next  = prod_reg[32:1];
                    3'd3:    pz_next  = prod_reg[31:0];
                    3'd4:    oz_next  = prod_reg[32:1];
                    3'd5:    sum_next = prod_reg;
                    3'd6:    sum_next = sum_reg + prod_reg;
                    3'd7:    sum_next = sum_reg + prod_reg;
                    default: ;
                endcase
                if (mul_cnt_reg == 3'd7)
                begin
                    if (mask_reg[0])
                    begin
                        state_next = S_SQRT_GO;
                    end
                    else
                    begin
                        div_idx_next = 3'd3;
                        state_next   = S_DIV_GO;
                    end
                end
            end
            S_SQRT_GO:
            begin
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (sq_rsp.done)
                begin
                    n_next       = sq_rsp.root;
                    div_idx_next = '0;
                    state_next   = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                if (div_idx_reg >= 3'd5)
                begin
                    state_next = S_OUT;
                end
                else if (job_en)
                begin
                    state_next = S_DIV_WAIT;
                end
                else
                begin
                    div_idx_next = div_idx_reg + 1'b1;
                end
            end
            S_DIV_WAIT:
            begin
                if (dv_rsp.done)
                begin
                    case (div_idx_reg)
                        3'd0, 3'd1, 3'd2:
                        begin
                            nrm_next[div_idx_reg[1:0]] = neg_reg[div_idx_reg[1:0]]
                                ? 16'(-dv_rsp.quot) : dv_rsp.quot[15:0];
                        end
                        3'd3:
                        begin
                            tu_next = dv_rsp.quot[16] ? 16'hFFFF : dv_rsp.quot[15:0];
                        end
                        default:
                        begin
                            tv_next = dv_rsp.quot[16] ? 16'hFFFF : dv_rsp.quot[15:0];
                        end
                    endcase
                    div_idx_next = div_idx_reg + 1'b1;
                    state_next   = S_DIV_GO;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    pos_x_next     = px_reg - (ctr_reg ? ox_reg : 32'd0);
                    pos_y_next     = py_reg;
                    pos_z_next     = pz_reg - (ctr_reg ? oz_reg : 32'd0);
                    onx_next       = nrm_reg[0];
                    ony_next       = nrm_reg[1];
                    onz_next       = nrm_reg[2];
                    otu_next       = tu_reg;
                    otv_next       = tv_reg;
                    state_next     = S_IDLE;
                    if (WW'(col_reg) + 1'b1 >= w_eff)
                    begin
                        col_next = '0;
                        if (17'(row_reg) + 17'd1 >= 17'(h_eff))
                        begin
                            row_next    = '0;
                            wp_next     = '0;
                            fill_next   = '0;
                            primed_next = 1'b0;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                hvn_pkg::REG_GRID_WIDTH:
                begin
                    gw_next = cfg_data[10:0];
                end
                hvn_pkg::REG_GRID_ROWS:
                begin
                    gr_next = cfg_data[15:0];
                end
                hvn_pkg::REG_SPACING_X:     sx_next   = cfg_data[30:0];
                hvn_pkg::REG_SPACING_Z:     sz_next   = cfg_data[30:0];
                hvn_pkg::REG_HEIGHT_OFFSET: off_next  = cfg_data;
                hvn_pkg::REG_UP_BIAS:       bias_next = cfg_data[30:0];
                hvn_pkg::REG_CENTER_ORIGIN: ctr_next  = cfg_data[0];
                hvn_pkg::REG_OUTPUT_MASK:   mask_next = cfg_data[1:0];
                default: ;
            endcase
            if (cfg_index == hvn_pkg::REG_GRID_WIDTH || cfg_index == hvn_pkg::REG_GRID_ROWS)
            begin
                col_next    = '0;
                row_next    = '0;
                wp_next     = '0;
                fill_next   = '0;
                primed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            primed_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            gw_reg        <= 11'd4;
            gr_reg        <= 16'd4;
            sx_reg        <= 31'd65536;
            sz_reg        <= 31'd65536;
            off_reg       <= '0;
            bias_reg      <= 31'd65536;
            ctr_reg       <= 1'b0;
            mask_reg      <= 2'd3;
            rd_cnt_reg    <= '0;
            mul_cnt_reg   <= '0;
            div_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            primed_reg    <= primed_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            gw_reg        <= gw_next;
            gr_reg        <= gr_next;
            sx_reg        <= sx_next;
            sz_reg        <= sz_next;
            off_reg       <= off_next;
            bias_reg      <= bias_next;
            ctr_reg       <= ctr_next;
            mask_reg      <= mask_next;
            rd_cnt_reg    <= rd_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            div_idx_reg   <= div_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        vs_reg     <= vs_next;
        hs_reg     <= hs_next;
        hl_reg     <= hl_next;
        hr_reg     <= hr_next;
        hd_reg     <= hd_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        px_reg     <= px_next;
        ox_reg     <= ox_next;
        pz_reg     <= pz_next;
        oz_reg     <= oz_next;
        sum_reg    <= sum_next;
        n_reg      <= n_next;
        py_reg     <= py_next;
        nrm_reg    <= nrm_next;
        tu_reg     <= tu_next;
        tv_reg     <= tv_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        pos_z_reg  <= pos_z_next;
        onx_reg    <= onx_next;
        ony_reg    <= ony_next;
        onz_reg    <= onz_next;
        otu_reg    <= otu_next;
        otv_reg    <= otv_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign norm_x    = onx_reg;
    assign norm_y    = ony_reg;
    assign norm_z    = onz_reg;
    assign tex_u     = otu_reg;
    assign tex_v     = otv_reg;

    a_tex_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mask_reg[1] |-> tex_u == 16'd0 && tex_v == 16'd0)
        else $error("texture coordinates not zero while disabled");

    a_up_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mask_reg[0] |-> !norm_y[15])
        else $error("vertical normal component negative");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        dv_req.start |-> !dv_rsp.busy && !sq_rsp.busy)
        else $error("divider started while busy");

    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ && rd_cnt_reg != 3'd4 |-> !ram_we)
        else $error("line store written before vertex reads finished");

endmodule

@@ rtl/core/hvn_ram.sv @@
// Generic simple dual-port RAM with registered read.
module hvn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/hvn_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module hvn_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  hvn_pkg::sqrt_req_t req,
    output hvn_pkg::sqrt_rsp_t rsp
);

    localparam int XW = hvn_pkg::SQ_XW;
    localparam int RW = hvn_pkg::SQ_RW;
    localparam int CW = $clog2(RW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [XW-1:0] x_reg, x_next;
    logic [XW-1:0] r_reg, r_next;
    logic [XW-1:0] bit_reg, bit_next;
    logic [XW-1:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = req.radicand;
            r_next    = '0;
            bit_next  = XW'(1) << (XW - 2);
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = r_reg[RW-1:0];

endmodule

@@ rtl/core/hvn_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hvn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hvn_pkg::div_req_t req,
    output hvn_pkg::div_rsp_t rsp
);

    localparam int NW = hvn_pkg::DIV_NW;
    localparam int DW = hvn_pkg::DIV_DW;
    localparam int QW = hvn_pkg::DIV_QW;
    localparam int SW = DW + QW - 1;
    localparam int CW = $clog2(QW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0] q_reg, q_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = SW'(req.num);
            dsh_next  = SW'(req.den) << (QW - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule
